// ----- rtl/sedi_pkg.sv -----
package sedi_pkg;

  // Field widths
  localparam int IntervalWidth  = 16;
  localparam int ThresholdWidth = 16;
  localparam int SkipWidth      = 3;
  localparam int FrameBits      = 40;
  localparam int BitCountWidth  = 6;
  localparam int HumidityWidth  = 16;
  localparam int TempWidth      = 16;
  localparam int ChecksumWidth  = 8;

  // Interval and threshold are compared at the wider of the two
  localparam int CmpWidth = (IntervalWidth > ThresholdWidth) ? IntervalWidth : ThresholdWidth;

  // Configuration port
  localparam int CfgIdxWidth  = 1;
  localparam int CfgDataWidth = 16;

  // Stream widths
  localparam int KindWidth    = 2;
  localparam int StatusWidth  = 2;
  localparam int InDataWidth  = ((IntervalWidth + 7) / 8) * 8;
  localparam int OutFieldBits = HumidityWidth + TempWidth + ChecksumWidth + BitCountWidth;
  localparam int OutDataWidth = ((OutFieldBits + 7) / 8) * 8;

  // Reset values of the configuration registers
  localparam logic [ThresholdWidth-1:0] ThresholdReset = ThresholdWidth'(110);
  localparam logic [SkipWidth-1:0]      SkipReset      = SkipWidth'(1);

  // Register indexes
  localparam logic [CfgIdxWidth-1:0] CfgThreshold = CfgIdxWidth'(0);
  localparam logic [CfgIdxWidth-1:0] CfgSkip      = CfgIdxWidth'(1);

  typedef enum logic [KindWidth-1:0] {
    KindStart   = 2'd0,
    KindEdge    = 2'd1,
    KindTimeout = 2'd2
  } kind_e;

  typedef enum logic [StatusWidth-1:0] {
    StatusOk     = 2'd0,
    StatusBadSum = 2'd1,
    StatusShort  = 2'd2
  } status_e;

  typedef struct packed {
    kind_e                    kind;
    logic [IntervalWidth-1:0] interval;
  } item_t;

  typedef struct packed {
    logic [HumidityWidth-1:0] humidity;
    logic [TempWidth-1:0]     temperature;
    logic [ChecksumWidth-1:0] checksum;
    status_e                  status;
    logic [BitCountWidth-1:0] bits_seen;
  } result_t;

endpackage

// ----- rtl/sensor_edge_interval_decoder_core.sv -----
// Channel  | Direction | Word contents (lowest bit first)
// ---------+-----------+---------------------------------------------------------
// s_axis   | in        | tdata: interval_us[15:0]; tuser: kind[1:0]
// m_axis   | out       | tdata: humidity_tenths, temperature_word, checksum_byte,
//          |           |        bits_seen, zero pad; tuser: status[1:0]
// cfg      | in        | cfg_we_i, cfg_idx_i (0 threshold, 1 skip), cfg_wdata_i
//
// One word per cycle while the result side is not stalled; a word passes
// through the input register, then through the frame decoder into the result
// register. Reset clears both registers' valid flags and the frame state and
// loads the threshold (110) and skip count (1). A stalled result holds the
// decoder word in place; the input register still takes a word when empty.
module sensor_edge_interval_decoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sedi_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [sedi_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sedi_pkg::InDataWidth-1:0]  s_axis_tdata,  // interval_us
  input  logic [sedi_pkg::KindWidth-1:0]    s_axis_tuser,  // kind
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // humidity_tenths, temperature_word, checksum_byte, bits_seen, pad
  output logic [sedi_pkg::OutDataWidth-1:0] m_axis_tdata,
  output logic [sedi_pkg::StatusWidth-1:0]  m_axis_tuser   // status
);
  import sedi_pkg::*;

  item_t   in_item, held_item;
  logic    held_valid, advance, out_ready, res_valid;
  result_t dec_result, out_result;

  assign in_item.kind     = kind_e'(s_axis_tuser);
  assign in_item.interval = s_axis_tdata[IntervalWidth-1:0];

  // Held word moves on once the result register can take its result
  assign advance = held_valid && out_ready;

  sedi_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .take_i  (advance),
    .valid_o (held_valid),
    .item_o  (held_item)
  );

  sedi_frame_dec u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (held_item),
    .commit_i    (advance),
    .res_valid_o (res_valid),
    .result_o    (dec_result)
  );

  sedi_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && res_valid),
    .result_i (dec_result),
    .ready_o  (out_ready),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  // Output word packing
  assign m_axis_tdata = OutDataWidth'({out_result.bits_seen, out_result.checksum,
                                       out_result.temperature, out_result.humidity});
  assign m_axis_tuser = out_result.status;

endmodule

// ----- rtl/sedi_in_stage.sv -----
module sedi_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  sedi_pkg::item_t item_i,
  input  logic           take_i,
  output logic           valid_o,
  output sedi_pkg::item_t item_o
);
  import sedi_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // Slot is free when empty or being drained this cycle
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/sedi_frame_dec.sv -----
module sedi_frame_dec (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sedi_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [sedi_pkg::CfgDataWidth-1:0]  cfg_wdata_i,
  input  sedi_pkg::item_t                    item_i,
  input  logic                               commit_i,
  output logic                               res_valid_o,
  output sedi_pkg::result_t                  result_o
);
  import sedi_pkg::*;

  // Configuration
  logic [ThresholdWidth-1:0] threshold_q;
  logic [SkipWidth-1:0]      skip_edges_q;

  // Frame state
  logic [FrameBits-1:0]     shift_q, shift_d;
  logic [BitCountWidth-1:0] bit_count_q, bit_count_d;
  logic [SkipWidth-1:0]     skip_count_q, skip_count_d;
  logic                     active_q, active_d;

  logic                     data_bit;
  logic [FrameBits-1:0]     shift_next;
  logic [ChecksumWidth-1:0] sum;

  // Bit decision and the shifted frame
  assign data_bit   = CmpWidth'(item_i.interval) > CmpWidth'(threshold_q);
  assign shift_next = {shift_q[FrameBits-2:0], data_bit};
  assign sum = shift_next[39:32] + shift_next[31:24] + shift_next[23:16] + shift_next[15:8];

  // Next state and result for the held word
  always_comb begin
    shift_d      = shift_q;
    bit_count_d  = bit_count_q;
    skip_count_d = skip_count_q;
    active_d     = active_q;
    res_valid_o  = 1'b0;
    result_o     = '0;
    case (item_i.kind)
      KindStart: begin
        shift_d      = '0;
        bit_count_d  = '0;
        skip_count_d = '0;
        active_d     = 1'b1;
      end
      KindEdge: begin
        if (active_q) begin
          if (skip_count_q < skip_edges_q) begin
            skip_count_d = skip_count_q + SkipWidth'(1);
          end else if (bit_count_q < BitCountWidth'(FrameBits)) begin
            shift_d     = shift_next;
            bit_count_d = bit_count_q + BitCountWidth'(1);
            if (bit_count_q == BitCountWidth'(FrameBits - 1)) begin
              active_d             = 1'b0;
              res_valid_o          = 1'b1;
              result_o.humidity    = shift_next[39:24];
              result_o.temperature = shift_next[23:8];
              result_o.checksum    = shift_next[7:0];
              result_o.status      = (sum == shift_next[7:0]) ? StatusOk : StatusBadSum;
              result_o.bits_seen   = BitCountWidth'(FrameBits);
            end
          end
        end
      end
      KindTimeout: begin
        if (active_q) begin
          active_d           = 1'b0;
          res_valid_o        = 1'b1;
          result_o.status    = StatusShort;
          result_o.bits_seen = bit_count_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= ThresholdReset;
      skip_edges_q <= SkipReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgThreshold: threshold_q  <= cfg_wdata_i[ThresholdWidth-1:0];
        CfgSkip:      skip_edges_q <= cfg_wdata_i[SkipWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  // Frame state, updated when the held word moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q      <= '0;
      bit_count_q  <= '0;
      skip_count_q <= '0;
      active_q     <= 1'b0;
    end else if (commit_i) begin
      shift_q      <= shift_d;
      bit_count_q  <= bit_count_d;
      skip_count_q <= skip_count_d;
      active_q     <= active_d;
    end
  end

endmodule

// ----- rtl/sedi_out_stage.sv -----
module sedi_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  sedi_pkg::result_t result_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output sedi_pkg::result_t result_o
);
  import sedi_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // Free when empty or being taken downstream this cycle
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- bench/tb_sensor_edge_interval_decoder_core.sv -----
module tb_sensor_edge_interval_decoder_core;
  import sedi_pkg::*;

  localparam logic [KindWidth-1:0] KindUnused = 2'd3;
  localparam int CycleLimit   = 400000;
  localparam int LongHold     = 300;
  localparam int SettleCycles = 6;
  localparam int TargetWords  = 1200;
  localparam int TargetFrames = 40;

  // Expected frames and the decoder state that produces them
  class frame_scoreboard;
    logic [ThresholdWidth-1:0] threshold;
    logic [SkipWidth-1:0]      skip_edges;
    logic [FrameBits-1:0]      frame_bits;
    logic [BitCountWidth-1:0]  bit_count;
    logic [SkipWidth-1:0]      skip_count;
    bit                        active;
    result_t                   pending_frames[$];
    int                        mismatches;
    int                        frames_predicted;

    function new();
      threshold        = ThresholdReset;
      skip_edges       = SkipReset;
      frame_bits       = '0;
      bit_count        = '0;
      skip_count       = '0;
      active           = 1'b0;
      mismatches       = 0;
      frames_predicted = 0;
    endfunction

    function void write_register(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] value);
      if (idx == CfgThreshold) begin
        threshold = value[ThresholdWidth-1:0];
      end else begin
        skip_edges = value[SkipWidth-1:0];
      end
    endfunction

    // Returns 1 when the word changed or could change the decoder
    function bit note_word(logic [KindWidth-1:0] kind, logic [IntervalWidth-1:0] interval);
      result_t    res;
      logic [7:0] sum;
      bit         used;
      res  = '0;
      used = active;
      case (kind)
        KindStart: begin
          frame_bits = '0;
          bit_count  = '0;
          skip_count = '0;
          active     = 1'b1;
          used       = 1'b1;
        end
        KindEdge: begin
          if (active) begin
            if (skip_count < skip_edges) begin
              skip_count++;
            end else if (bit_count < FrameBits) begin
              frame_bits = {frame_bits[FrameBits-2:0], interval > threshold};
              bit_count++;
              if (bit_count == FrameBits) begin
                res.humidity    = frame_bits[39:24];
                res.temperature = frame_bits[23:8];
                res.checksum    = frame_bits[7:0];
                sum = frame_bits[39:32] + frame_bits[31:24] + frame_bits[23:16]
                    + frame_bits[15:8];
                res.status      = (sum == frame_bits[7:0]) ? StatusOk : StatusBadSum;
                res.bits_seen   = bit_count;
                active          = 1'b0;
                pending_frames.push_back(res);
                frames_predicted++;
              end
            end
          end
        end
        KindTimeout: begin
          if (active) begin
            res.status    = StatusShort;
            res.bits_seen = bit_count;
            active        = 1'b0;
            pending_frames.push_back(res);
            frames_predicted++;
          end
        end
        default: ;
      endcase
      return used;
    endfunction

    function void flag(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h got %0h", what, want, got);
    endfunction

    function void check_result(logic [OutDataWidth-1:0] data, logic [StatusWidth-1:0] user);
      result_t want;
      if (pending_frames.size() == 0) begin
        flag("unexpected word, data", 0, data);
        return;
      end
      want = pending_frames.pop_front();
      if (data[15:0] !== want.humidity)    flag("humidity", want.humidity, data[15:0]);
      if (data[31:16] !== want.temperature) flag("temperature", want.temperature, data[31:16]);
      if (data[39:32] !== want.checksum)   flag("checksum", want.checksum, data[39:32]);
      if (data[45:40] !== want.bits_seen)  flag("bits_seen", want.bits_seen, data[45:40]);
      if (data[OutDataWidth-1:OutFieldBits] !== '0)
        flag("pad", 0, data[OutDataWidth-1:OutFieldBits]);
      if (user !== want.status)            flag("status", want.status, user);
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i = '0;
  logic [CfgDataWidth-1:0] cfg_wdata_i = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic [KindWidth-1:0]    s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic [StatusWidth-1:0]  m_axis_tuser;

  frame_scoreboard sb = new();
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  int  words_sent = 0;
  int  cycle_count = 0;

  sensor_edge_interval_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Interval that decodes as the wanted bit, often right at the threshold
  function automatic logic [IntervalWidth-1:0] bit_interval(bit one);
    int thr;
    thr = sb.threshold;
    if (one && thr != 65535) begin
      if ($urandom_range(0, 3) == 0) return IntervalWidth'(thr + 1);
      return IntervalWidth'($urandom_range(thr + 1, 65535));
    end
    case ($urandom_range(0, 3))
      0:       return IntervalWidth'(thr);
      1:       return '0;
      default: return IntervalWidth'($urandom_range(0, thr));
    endcase
  endfunction

  // One word on the input stream, then a random gap
  task automatic offer_word(logic [KindWidth-1:0] kind, logic [IntervalWidth-1:0] interval);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= interval;
    do @(posedge clk_i); while (!s_axis_tready);
    if (sb.note_word(kind, interval)) words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sender waits until every frame is out and the pipeline is empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_frames.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic configure(logic [ThresholdWidth-1:0] thr, logic [SkipWidth-1:0] skip);
    logic [CfgDataWidth-1:0] skip_word;
    skip_word = CfgDataWidth'($urandom);
    skip_word[SkipWidth-1:0] = skip;
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgThreshold;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    sb.write_register(CfgThreshold, thr);
    cfg_idx_i   <= CfgSkip;
    cfg_wdata_i <= skip_word;
    @(posedge clk_i);
    sb.write_register(CfgSkip, skip_word);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Frame with random payload and usually a matching checksum, sometimes cut short or overrun
  task automatic send_frame();
    logic [FrameBits-1:0] payload;
    int                   n_bits;
    int                   roll;
    payload = FrameBits'({$urandom, $urandom});
    if ($urandom_range(0, 3) != 0)
      payload[7:0] = payload[39:32] + payload[31:24] + payload[23:16] + payload[15:8];
    roll   = $urandom_range(0, 99);
    n_bits = (roll < 80) ? FrameBits : $urandom_range(0, FrameBits - 1);
    offer_word(KindStart, IntervalWidth'($urandom));
    repeat (sb.skip_edges) offer_word(KindEdge, IntervalWidth'($urandom));
    for (int i = 0; i < n_bits; i++)
      offer_word(KindEdge, bit_interval(payload[FrameBits-1-i]));
    if (n_bits < FrameBits) begin
      // short frame ends in a timeout, or is dropped by the next start
      if ($urandom_range(0, 2) != 0) offer_word(KindTimeout, IntervalWidth'($urandom));
    end else begin
      // trailing edges and a late timeout must be ignored
      repeat ($urandom_range(0, 2)) offer_word(KindEdge, IntervalWidth'($urandom));
      if ($urandom_range(0, 3) == 0) offer_word(KindTimeout, IntervalWidth'($urandom));
    end
  endtask

  task automatic random_phase(int words);
    int stop_at;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) send_frame();
      else offer_word(KindWidth'($urandom_range(0, 3)), IntervalWidth'($urandom));
    end
  endtask

  // Result side: random back-pressure plus one long hold on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LongHold;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("sensor_edge_interval_decoder_core verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle words, short frames, threshold edges, restart, unused kind
    offer_word(KindEdge, 16'hFFFF);
    offer_word(KindTimeout, 16'h0000);
    offer_word(KindUnused, 16'hFFFF);
    offer_word(KindStart, 16'h0000);
    offer_word(KindTimeout, 16'h0000);
    offer_word(KindTimeout, 16'h0000);
    offer_word(KindStart, 16'hFFFF);
    offer_word(KindEdge, 16'h0000);
    offer_word(KindEdge, 16'h0000);
    offer_word(KindEdge, 16'd110);
    offer_word(KindEdge, 16'd111);
    offer_word(KindEdge, 16'hFFFF);
    offer_word(KindUnused, 16'h0000);
    offer_word(KindStart, 16'h0000);
    offer_word(KindEdge, 16'd5);
    offer_word(KindEdge, 16'd200);
    offer_word(KindTimeout, 16'hFFFF);
    drain();

    // Long receiver hold while short frames pile up behind it
    hold_req = 1'b1;
    repeat (8) begin
      offer_word(KindStart, IntervalWidth'($urandom));
      offer_word(KindTimeout, IntervalWidth'($urandom));
    end
    drain();

    // Random phases over several register settings
    random_phase(200);
    configure(16'd0, 3'd0);
    random_phase(200);
    configure(16'hFFFF, 3'd7);
    random_phase(150);
    calm = 1'b1;
    configure(ThresholdWidth'($urandom_range(40, 200)), SkipWidth'($urandom_range(0, 7)));
    random_phase(200);
    calm = 1'b0;
    configure(ThresholdWidth'($urandom), SkipWidth'($urandom));
    random_phase(200);
    configure(16'd110, 3'd1);
    while (words_sent < TargetWords || sb.frames_predicted < TargetFrames) send_frame();

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_frames.size() == 0) begin
      $display("sensor_edge_interval_decoder_core verification clean");
    end else begin
      $display("sensor_edge_interval_decoder_core verification failed");
    end
    $finish;
  end

endmodule
